// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths and item types for the rotation matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

   localparam int DATA_WIDTH = 16;
   localparam int FRAC_BITS  = DATA_WIDTH - 2;
   localparam int T_W        = DATA_WIDTH + 3;
   localparam int MAG_W      = DATA_WIDTH + 1;
   localparam int SQ_W       = 2 * MAG_W;
   localparam int NSQ_W      = SQ_W + 2;
   localparam int ROOT_STEPS = NSQ_W / 2;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int ACC_W      = NSQ_W + 1;
   localparam int Q_W        = FRAC_BITS + 1;
   localparam int NUM_W      = MAG_W + FRAC_BITS + 1;
   localparam int DREM_W     = ROOT_W + 1;
   localparam int LANES      = 4;
   localparam int NUM_STAGES = 3 + ROOT_STEPS + Q_W;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = 2;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic [LANES-1:0]            neg;
      logic [LANES-1:0][MAG_W-1:0] mag;
   } item_type;

   typedef struct packed {
      logic push_valid;
   } push_ctl_type;

endpackage

// ===== sv/rmq_req_if.sv =====
// ----------------------------------------------------------------------------
// rmq_req_if
// Matrix item channel: nine signed elements with valid and ready.
// ----------------------------------------------------------------------------
interface rmq_req_if;
   logic valid;
   logic ready;
   rmq_pkg::data_type m00, m01, m02, m10, m11, m12, m20, m21, m22;

   modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   input ready);
   modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                   output ready);
endinterface

// ===== sv/rmq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rmq_rsp_if
// Quaternion item channel: four signed components with valid and ready.
// ----------------------------------------------------------------------------
interface rmq_rsp_if;
   logic valid;
   logic ready;
   rmq_pkg::data_type quat_w, quat_x, quat_y, quat_z;

   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== sv/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix, picks the largest estimate and forms the scaled vector.
// ----------------------------------------------------------------------------
module rmq_front (
   input  logic                clock,
   input  logic                reset,
   rmq_req_if.sink             req_ch,
   output rmq_pkg::push_ctl_type ctl_out,
   input  logic                push_ready,
   output rmq_pkg::item_type   push_item
);

   localparam logic signed [rmq_pkg::T_W-1:0] ONE =
      rmq_pkg::T_W'(1) << rmq_pkg::FRAC_BITS;

   logic                     valid_ff, valid_in;
   rmq_pkg::item_type        item_ff, item_in;
   logic signed [rmq_pkg::T_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
   logic signed [rmq_pkg::T_W-1:0] t0, t1, t2, t3;
   logic signed [rmq_pkg::T_W-1:0] vw, vx, vy, vz;
   logic signed [rmq_pkg::T_W-1:0] vec [rmq_pkg::LANES];
   logic signed [rmq_pkg::T_W-1:0] av;
   logic [1:0]               sel;
   logic                     take;

   always_comb begin
      e00 = rmq_pkg::T_W'(req_ch.m00);
      e01 = rmq_pkg::T_W'(req_ch.m01);
      e02 = rmq_pkg::T_W'(req_ch.m02);
      e10 = rmq_pkg::T_W'(req_ch.m10);
      e11 = rmq_pkg::T_W'(req_ch.m11);
      e12 = rmq_pkg::T_W'(req_ch.m12);
      e20 = rmq_pkg::T_W'(req_ch.m20);
      e21 = rmq_pkg::T_W'(req_ch.m21);
      e22 = rmq_pkg::T_W'(req_ch.m22);
      t0 = ONE + e00 + e11 + e22;
      t1 = ONE + e00 - e11 - e22;
      t2 = ONE - e00 + e11 - e22;
      t3 = ONE - e00 - e11 + e22;
      if (t0 > t1) begin
         if (t0 > t2) sel = (t0 > t3) ? 2'd0 : 2'd3;
         else         sel = (t2 > t3) ? 2'd2 : 2'd3;
      end else begin
         if (t1 > t2) sel = (t1 > t3) ? 2'd1 : 2'd3;
         else         sel = (t2 > t3) ? 2'd2 : 2'd3;
      end
      case (sel)
         2'd0: begin
            vw = t0; vx = e21 - e12; vy = e02 - e20; vz = e10 - e01;
         end
         2'd1: begin
            vx = t1; vw = e21 - e12; vy = e01 + e10; vz = e02 + e20;
         end
         2'd2: begin
            vy = t2; vw = e02 - e20; vz = e12 + e21; vx = e10 + e01;
         end
         default: begin
            vz = t3; vw = e10 - e01; vx = e20 + e02; vy = e21 + e12;
         end
      endcase
      if (vw < 0) begin
         vec[0] = -vw; vec[1] = -vx; vec[2] = -vy; vec[3] = -vz;
      end else begin
         vec[0] = vw;  vec[1] = vx;  vec[2] = vy;  vec[3] = vz;
      end
      for (int i = 0; i < rmq_pkg::LANES; i++) begin
         av = (vec[i] < 0) ? -vec[i] : vec[i];
         item_in.neg[i] = vec[i][rmq_pkg::T_W-1];
         item_in.mag[i] = av[rmq_pkg::MAG_W-1:0];
      end
   end

   assign req_ch.ready = !valid_ff || push_ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign valid_in     = take ? 1'b1 : (valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign ctl_out.push_valid = valid_ff;
   assign push_item          = item_ff;

endmodule

// ===== sv/rmq_fifo.sv =====
// ----------------------------------------------------------------------------
// rmq_fifo
// Short item queue between the front and the arithmetic back end.
// ----------------------------------------------------------------------------
module rmq_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  rmq_pkg::push_ctl_type ctl_in,
   output logic                  push_ready,
   input  rmq_pkg::item_type     push_item,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output rmq_pkg::item_type     pop_item
);

   rmq_pkg::item_type            mem [rmq_pkg::FIFO_DEPTH];
   logic [rmq_pkg::FIFO_AW-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rmq_pkg::FIFO_AW:0]    count_ff, count_in;
   logic                         do_push, do_pop;

   assign push_ready = (count_ff != (rmq_pkg::FIFO_AW+1)'(rmq_pkg::FIFO_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign do_push    = ctl_in.push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;
   assign pop_item   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (rmq_pkg::FIFO_AW+1)'(rmq_pkg::FIFO_DEPTH))
      else $error("queue count beyond depth");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count lost a push");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[rmq_pkg::FIFO_AW-1:0])
      else $error("queue pointers disagree with count");
`endif

endmodule

// ===== sv/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined norm, square root and per-lane division to the unit quaternion.
// ----------------------------------------------------------------------------
module rmq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  rmq_pkg::item_type pop_item,
   rmq_rsp_if.source         rsp_ch
);

   localparam int NS   = rmq_pkg::NUM_STAGES;
   localparam int RS   = rmq_pkg::ROOT_STEPS;
   localparam int QW   = rmq_pkg::Q_W;
   localparam int L    = rmq_pkg::LANES;
   localparam int AW   = rmq_pkg::ACC_W;
   localparam int DW   = rmq_pkg::DATA_WIDTH;
   localparam int FB   = rmq_pkg::FRAC_BITS;

   logic                           en;
   logic                           vld_ff [NS];
   rmq_pkg::item_type              car_ff [NS];
   logic [L-1:0][rmq_pkg::SQ_W-1:0] sq_ff, sq_in;
   logic [AW-1:0]                  rem_ff [RS+1];
   logic [AW-1:0]                  res_ff [RS+1];
   logic [AW-1:0]                  rem_in [RS+1];
   logic [AW-1:0]                  res_in [RS+1];
   logic [AW-1:0]                  nsq_in;
   logic [AW-1:0]                  bitv, trial;
   logic [rmq_pkg::ROOT_W-1:0]     den_ff [QW+1];
   logic [rmq_pkg::ROOT_W-1:0]     den_in [QW+1];
   logic [L-1:0][QW-1:0]           low_ff [QW+1];
   logic [L-1:0][QW-1:0]           low_in [QW+1];
   logic [L-1:0][rmq_pkg::DREM_W-1:0] dr_ff [QW+1];
   logic [L-1:0][rmq_pkg::DREM_W-1:0] dr_in [QW+1];
   logic [L-1:0][QW-1:0]           q_ff [QW+1];
   logic [L-1:0][QW-1:0]           q_in [QW+1];
   logic [rmq_pkg::ROOT_W-1:0]     root;
   logic [rmq_pkg::NUM_W-1:0]      num;
   logic [rmq_pkg::DREM_W-1:0]     shifted;
   logic                           out_valid_ff, out_valid_in;
   logic [L-1:0][DW-1:0]           out_ff, out_in;
   logic signed [DW:0]             sq_val;

   assign en        = !out_valid_ff || rsp_ch.ready;
   assign pop_ready = en;

   always_comb begin
      for (int i = 0; i < L; i++) begin
         sq_in[i] = pop_item.mag[i] * pop_item.mag[i];
      end
      nsq_in = '0;
      for (int i = 0; i < L; i++) begin
         nsq_in = nsq_in + AW'(sq_ff[i]);
      end
      rem_in[0] = nsq_in;
      res_in[0] = '0;
      for (int k = 0; k < RS; k++) begin
         bitv  = AW'(1) << (2 * (RS - 1 - k));
         trial = res_ff[k] + bitv;
         if (rem_ff[k] >= trial) begin
            rem_in[k+1] = rem_ff[k] - trial;
            res_in[k+1] = (res_ff[k] >> 1) + bitv;
         end else begin
            rem_in[k+1] = rem_ff[k];
            res_in[k+1] = res_ff[k] >> 1;
         end
      end
      root = res_ff[RS][rmq_pkg::ROOT_W-1:0];
      if (root == '0) root = rmq_pkg::ROOT_W'(1);
      den_in[0] = root;
      for (int i = 0; i < L; i++) begin
         num = ({rmq_pkg::NUM_W'(car_ff[RS+1].mag[i])} << FB)
               + rmq_pkg::NUM_W'(root >> 1);
         low_in[0][i] = num[QW-1:0];
         dr_in[0][i]  = rmq_pkg::DREM_W'(num >> QW);
         q_in[0][i]   = '0;
      end
      for (int d = 0; d < QW; d++) begin
         den_in[d+1] = den_ff[d];
         for (int i = 0; i < L; i++) begin
            shifted = {dr_ff[d][i][rmq_pkg::DREM_W-2:0], low_ff[d][i][QW-1-d]};
            low_in[d+1][i] = low_ff[d][i];
            if (shifted >= rmq_pkg::DREM_W'(den_ff[d])) begin
               dr_in[d+1][i] = shifted - rmq_pkg::DREM_W'(den_ff[d]);
               q_in[d+1][i]  = {q_ff[d][i][QW-2:0], 1'b1};
            end else begin
               dr_in[d+1][i] = shifted;
               q_in[d+1][i]  = {q_ff[d][i][QW-2:0], 1'b0};
            end
         end
      end
      for (int i = 0; i < L; i++) begin
         sq_val = car_ff[NS-1].neg[i] ? -(DW+1)'(q_ff[QW][i])
                                      :  (DW+1)'(q_ff[QW][i]);
         if (sq_val > $signed((DW+1)'((1 << (DW-1)) - 1)))
            out_in[i] = {1'b0, {(DW-1){1'b1}}};
         else if (sq_val < -$signed((DW+1)'(1 << (DW-1))))
            out_in[i] = {1'b1, {(DW-1){1'b0}}};
         else
            out_in[i] = sq_val[DW-1:0];
      end
      out_valid_in = en ? vld_ff[NS-1] : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NS; s++) vld_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (en) begin
            vld_ff[0] <= pop_valid;
            for (int s = 1; s < NS; s++) vld_ff[s] <= vld_ff[s-1];
         end
      end
      if (en) begin
         car_ff[0] <= pop_item;
         for (int s = 1; s < NS; s++) car_ff[s] <= car_ff[s-1];
         sq_ff <= sq_in;
         for (int k = 0; k <= RS; k++) begin
            rem_ff[k] <= rem_in[k];
            res_ff[k] <= res_in[k];
         end
         for (int d = 0; d <= QW; d++) begin
            den_ff[d] <= den_in[d];
            low_ff[d] <= low_in[d];
            dr_ff[d]  <= dr_in[d];
            q_ff[d]   <= q_in[d];
         end
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.quat_w = out_ff[0];
   assign rsp_ch.quat_x = out_ff[1];
   assign rsp_ch.quat_y = out_ff[2];
   assign rsp_ch.quat_z = out_ff[3];

`ifndef SYNTHESIS
   a_w_nonneg: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !rsp_ch.quat_w[DW-1])
      else $error("scalar part negative");
   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      vld_ff[RS+1] |-> res_ff[RS] != '0)
      else $error("norm root is zero");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (en && vld_ff[NS-1]) |=> out_valid_ff)
      else $error("finished item not presented");
`endif

endmodule

// ===== sv/rotation_matrix_to_quaternion_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_core
// Shepperd rotation matrix to unit quaternion, signed Q1.14 in and out.
// ----------------------------------------------------------------------------
// One matrix item is taken per cycle while the front register is free or the
// queue has room, and one quaternion item returns for each, in order. The
// result passes the front register, the queue memory, the squaring register,
// then 36 back-end stages: one sum stage, an 18-stage bit-per-stage square
// root of the norm, one numerator stage, a 15-stage restoring divider that
// runs all four lanes at once, and the output register.
// The back end advances only while its output register is free, and the
// four-entry queue absorbs the front while it waits.
module rotation_matrix_to_quaternion_core (
   input  logic      clock,
   input  logic      reset,
   rmq_req_if.sink   req_ch,
   rmq_rsp_if.source rsp_ch
);

   rmq_pkg::push_ctl_type ctl;
   logic                  push_ready;
   rmq_pkg::item_type     push_item;
   logic                  pop_valid, pop_ready;
   rmq_pkg::item_type     pop_item;

   rmq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .ctl_out    (ctl),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   rmq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .ctl_in     (ctl),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   rmq_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp_ch    (rsp_ch)
   );

endmodule
